// ===== src/klvsd_pkg.sv =====
`default_nettype none

package klvsd_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_KEY      = 3'd0,
        PH_LEN_HI   = 3'd1,
        PH_LEN_LO   = 3'd2,
        PH_VALUE    = 3'd3,
        PH_CK_LEN   = 3'd4,
        PH_CK_VALUE = 3'd5
    } t_phase;

    // byte role codes
    localparam logic [2:0] ROLE_KEY      = 3'd0;
    localparam logic [2:0] ROLE_LENGTH   = 3'd1;
    localparam logic [2:0] ROLE_VALUE    = 3'd2;
    localparam logic [2:0] ROLE_CHECKSUM = 3'd3;
    localparam logic [2:0] ROLE_IGNORED  = 3'd4;

    // frame status codes
    localparam logic [2:0] STAT_NOT_LAST  = 3'd0;
    localparam logic [2:0] STAT_COMPLETE  = 3'd1;
    localparam logic [2:0] STAT_CRC_OK    = 3'd2;
    localparam logic [2:0] STAT_CRC_BAD   = 3'd3;
    localparam logic [2:0] STAT_TRUNCATED = 3'd4;

    // configuration register indexes
    localparam logic CFG_KEY_MODE = 1'b0;
    localparam logic CFG_CRC_EN   = 1'b1;

    // crc-16-ccitt constants
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [7:0]  CRC_TAG    = 8'h01;
    localparam logic [7:0]  CRC_LEN    = 8'h02;

    // one labeled result item
    typedef struct packed {
        logic [7:0]  echo_byte;
        logic [2:0]  byte_role;
        logic [3:0]  key_position;
        logic [15:0] value_position;
        logic [15:0] element_length;
        logic        element_done;
        logic [2:0]  frame_status;
        logic [15:0] computed_checksum;
    } t_result;

endpackage

`default_nettype wire

// ===== src/klvsd_parse.sv =====
`default_nettype none

module klvsd_parse
    import klvsd_pkg::*;
#(
    parameter int KEY_BYTES = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_take,
    input  wire logic [7:0] i_byte,
    input  wire logic    i_last,
    input  wire logic    i_key_mode,
    input  wire logic    i_crc_en,
    output t_result      o_result
);

    localparam logic [4:0] KeyCount = 5'(KEY_BYTES);

    // one byte of crc-16-ccitt, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_key_count, n_key_count;
    logic [15:0] r_length_accum, n_length_accum;
    logic [15:0] r_value_count, n_value_count;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_crc_at_tag, n_crc_at_tag;
    logic [15:0] r_rx_crc, n_rx_crc;
    logic        r_stopped, n_stopped;

    logic [15:0] len_lo;
    logic [15:0] value_next;
    logic        verified;
    t_result     res;

    // next state and result for the current byte
    always_comb begin
        n_phase        = r_phase;
        n_key_count    = r_key_count;
        n_length_accum = r_length_accum;
        n_value_count  = r_value_count;
        n_crc          = r_crc;
        n_crc_at_tag   = r_crc_at_tag;
        n_rx_crc       = r_rx_crc;
        n_stopped      = r_stopped;
        verified       = 1'b0;
        res            = '0;
        res.echo_byte  = i_byte;
        len_lo = ((r_phase == PH_CK_LEN) ? 16'h0000 : r_length_accum) | {8'h00, i_byte};
        value_next = r_value_count + 16'd1;

        if (r_stopped) begin
            res.byte_role = ROLE_IGNORED;
        end else begin
            case (r_phase)
                PH_KEY: begin
                    if (i_key_mode) begin
                        res.byte_role    = ROLE_KEY;
                        res.key_position = r_key_count;
                        if (({1'b0, r_key_count} + 5'd1) >= KeyCount) begin
                            n_key_count = '0;
                            n_phase     = PH_LEN_HI;
                        end else begin
                            n_key_count = r_key_count + 4'd1;
                        end
                    end else begin
                        n_key_count    = '0;
                        n_length_accum = '0;
                        if (i_crc_en && i_byte == CRC_TAG) begin
                            res.byte_role = ROLE_CHECKSUM;
                            n_crc_at_tag  = r_crc;
                            n_phase       = PH_CK_LEN;
                        end else begin
                            res.byte_role = ROLE_KEY;
                            n_phase       = PH_LEN_LO;
                        end
                    end
                end
                PH_LEN_HI: begin
                    res.byte_role      = ROLE_LENGTH;
                    n_length_accum     = {i_byte, 8'h00};
                    res.element_length = {i_byte, 8'h00};
                    n_phase            = PH_LEN_LO;
                end
                PH_LEN_LO, PH_CK_LEN: begin
                    if (r_phase == PH_CK_LEN && i_byte == CRC_LEN) begin
                        res.byte_role      = ROLE_CHECKSUM;
                        n_length_accum     = 16'd2;
                        res.element_length = 16'd2;
                        n_value_count      = '0;
                        n_phase            = PH_CK_VALUE;
                    end else begin
                        res.byte_role      = ROLE_LENGTH;
                        n_length_accum     = len_lo;
                        res.element_length = len_lo;
                        n_value_count      = '0;
                        if (len_lo == 16'd0) begin
                            res.element_done = 1'b1;
                            n_phase          = PH_KEY;
                        end else begin
                            n_phase = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: begin
                    res.byte_role      = ROLE_VALUE;
                    res.value_position = r_value_count;
                    res.element_length = r_length_accum;
                    n_value_count      = value_next;
                    if (value_next >= r_length_accum) begin
                        res.element_done = 1'b1;
                        n_value_count    = '0;
                        n_phase          = PH_KEY;
                    end
                end
                PH_CK_VALUE: begin
                    res.byte_role      = ROLE_CHECKSUM;
                    res.value_position = {15'd0, r_value_count[0]};
                    res.element_length = 16'd2;
                    if (r_value_count == 16'd0) begin
                        n_rx_crc      = {i_byte, 8'h00};
                        n_value_count = 16'd1;
                    end else begin
                        n_rx_crc         = {r_rx_crc[15:8], i_byte};
                        n_value_count    = '0;
                        res.element_done = 1'b1;
                        verified         = i_last;
                        n_phase          = PH_KEY;
                    end
                end
                default: begin
                    n_phase = PH_KEY;
                end
            endcase

            n_crc = crc_byte(r_crc, i_byte);

            // frame status on the last byte
            if (i_last) begin
                n_stopped = 1'b1;
                if (verified) begin
                    res.computed_checksum = r_crc_at_tag;
                    res.frame_status = (n_rx_crc == r_crc_at_tag) ? STAT_CRC_OK : STAT_CRC_BAD;
                end else begin
                    res.computed_checksum = n_crc;
                    res.frame_status = res.element_done ? STAT_COMPLETE : STAT_TRUNCATED;
                end
            end
        end
    end

    assign o_result = res;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_KEY;
            r_key_count    <= '0;
            r_length_accum <= '0;
            r_value_count  <= '0;
            r_crc          <= CRC_PRESET;
            r_crc_at_tag   <= CRC_PRESET;
            r_rx_crc       <= '0;
            r_stopped      <= 1'b0;
        end else if (i_take) begin
            r_phase        <= n_phase;
            r_key_count    <= n_key_count;
            r_length_accum <= n_length_accum;
            r_value_count  <= n_value_count;
            r_crc          <= n_crc;
            r_crc_at_tag   <= n_crc_at_tag;
            r_rx_crc       <= n_rx_crc;
            r_stopped      <= n_stopped;
        end
    end

    // checks
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last) |=> r_stopped)
        else $error("last byte did not stop the parser");

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared without reset");

    a_value_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VALUE) |-> (r_value_count < r_length_accum))
        else $error("value count ran past element length");

    a_ck_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CK_VALUE) |-> (r_length_accum == 16'd2 && r_value_count < 16'd2))
        else $error("checksum element state inconsistent");

endmodule

`default_nettype wire

// ===== src/klv_set_deframer_crc16_top.sv =====
// KLV set deframer: takes a frame one byte per item on the slave stream and
// returns one labeled item per byte on the master stream (role in tuser,
// element end in tlast). Each byte is parsed by combinational logic
// between the input handshake and the output register, so the block takes
// one byte every clock; the result appears in the cycle after the byte is
// accepted, and the input is held off only while a result waits and the
// receiver is not ready.
// The CRC-16-CCITT update is unrolled to one byte per cycle whenever a byte
// is accepted. After a byte with tlast the block labels every byte as ignored
// until reset. Configuration (index 0 key mode, index 1 checksum enable) must
// be written only while the stream is idle; the block itself does not enforce this.
`default_nettype none

module klv_set_deframer_crc16_top
    import klvsd_pkg::*;
#(
    parameter int KEY_BYTES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] frame_byte
    input  wire logic        i_s_tlast,   // frame_last
    // master stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [7:0] echo_byte, [11:8] key_position, [27:12] value_position,
    // [43:28] element_length, [46:44] frame_status, [62:47] computed_checksum
    output logic [63:0]      o_m_tdata,
    output logic [2:0]       o_m_tuser,   // [2:0] byte_role
    output logic             o_m_tlast,   // element_done
    // configuration write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic        i_cfg_data
);

    logic    r_key_mode;
    logic    r_crc_en;
    logic    r_out_valid;
    t_result r_out;
    t_result res;
    logic    take;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign take        = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_mode <= 1'b0;
            r_crc_en   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY_MODE: r_key_mode <= i_cfg_data;
                CFG_CRC_EN:   r_crc_en   <= i_cfg_data;
                default:      r_key_mode <= r_key_mode;
            endcase
        end
    end

    klvsd_parse #(
        .KEY_BYTES (KEY_BYTES)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_byte     (i_s_tdata),
        .i_last     (i_s_tlast),
        .i_key_mode (r_key_mode),
        .i_crc_en   (r_crc_en),
        .o_result   (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.byte_role;
    assign o_m_tlast  = r_out.element_done;
    assign o_m_tdata  = {1'b0, r_out.computed_checksum, r_out.frame_status,
                         r_out.element_length, r_out.value_position,
                         r_out.key_position, r_out.echo_byte};

    // checks
    a_ignored_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.byte_role == ROLE_IGNORED) |->
        (r_out.frame_status == STAT_NOT_LAST && r_out.computed_checksum == 16'd0
         && !r_out.element_done))
        else $error("ignored byte carries parse fields");

    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_s_tlast) |=> (r_out.frame_status == STAT_NOT_LAST))
        else $error("frame status set on a byte that is not last");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_out_valid)
        else $error("accepted byte produced no result");

endmodule

`default_nettype wire
